[rtl/core/q24alu_pkg.sv]
// q24alu_pkg: shared constants, codes, word types and helper functions
// for the Q24.8 fixed-point ALU; used by q24alu_div and q24_8_fixed_point_alu
`default_nettype none

package q24alu_pkg;

  // number format
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 8;

  // divider geometry: one quotient bit per step, two steps per stage
  localparam int DIV_BITS      = WORD_BITS + FRAC_BITS;
  localparam int DIV_PER_STAGE = 2;
  localparam int DIV_STAGES    = (DIV_BITS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

  // main pipeline: decode, multiply, mul pack, ..., final pack / output register
  localparam int PIPE_LAST = DIV_STAGES + 3;

  // saturation ends
  localparam logic [WORD_BITS-1:0] WORD_SIGN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [WORD_BITS-1:0] WORD_MAX  = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WORD_ONE  = {{(WORD_BITS-1){1'b0}}, 1'b1};

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_LE, OP_GT, OP_GE,
    OP_EQ, OP_NE, OP_MIN, OP_MAX, OP_INC, OP_DEC, OP_FROM_INT, OP_TO_INT
  } op_t;

  typedef enum logic [1:0] {
    FLT_NONE = 2'd0,
    FLT_OVF  = 2'd1,
    FLT_DIV0 = 2'd2
  } fault_t;

  typedef struct packed {
    logic [3:0]                  op;
    logic signed [WORD_BITS-1:0] a_raw;
    logic signed [WORD_BITS-1:0] b_raw;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] result_raw;
    logic                        compare_true;
    logic [1:0]                  fault;
  } out_word_t;

  // result and fault pair
  typedef struct packed {
    logic [WORD_BITS-1:0] res;
    fault_t               fault;
  } calc_t;

  // one item in the main pipeline
  typedef struct packed {
    logic                 valid;
    op_t                  op;
    logic                 neg;
    logic [WORD_BITS-1:0] res;
    logic                 cmp;
    fault_t               fault;
  } mid_t;

  // divider stage contents
  typedef struct packed {
    logic [WORD_BITS-1:0] rem;
    logic [DIV_BITS-1:0]  nrem;
    logic [DIV_BITS-1:0]  q;
    logic [WORD_BITS-1:0] d;
  } div_stage_t;

  // rounded quotient magnitude from the divider
  typedef struct packed {
    logic [DIV_BITS:0] q;
    logic              dz;
  } div_res_t;

  // magnitude of a two's complement word
  function automatic logic [WORD_BITS-1:0] mag_of(input logic [WORD_BITS-1:0] v);
    return v[WORD_BITS-1] ? ((~v) + WORD_ONE) : v;
  endfunction

  function automatic logic [WORD_BITS-1:0] sat_val(input logic neg);
    return neg ? WORD_SIGN : WORD_MAX;
  endfunction

  // signed result from sign and magnitude, saturating on overflow
  function automatic calc_t pack_mag(input logic neg, input logic [2*WORD_BITS:0] m);
    logic [2*WORD_BITS:0] lim;
    calc_t                r;
    lim = {{(WORD_BITS+1){1'b0}}, WORD_SIGN};
    if (!neg) begin
      lim = {{(WORD_BITS+1){1'b0}}, WORD_MAX};
    end
    if (m > lim) begin
      r.res   = sat_val(neg);
      r.fault = FLT_OVF;
    end else begin
      r.res   = neg ? ((~m[WORD_BITS-1:0]) + WORD_ONE) : m[WORD_BITS-1:0];
      r.fault = FLT_NONE;
    end
    return r;
  endfunction

  // one restoring division step
  function automatic div_stage_t div_step(input div_stage_t s);
    logic [WORD_BITS:0] r;
    div_stage_t         o;
    r      = {s.rem, s.nrem[DIV_BITS-1]};
    o      = s;
    o.nrem = {s.nrem[DIV_BITS-2:0], 1'b0};
    o.q    = {s.q[DIV_BITS-2:0], 1'b0};
    if (r >= {1'b0, s.d}) begin
      r      = r - {1'b0, s.d};
      o.q[0] = 1'b1;
    end
    o.rem = r[WORD_BITS-1:0];
    return o;
  endfunction

endpackage

`default_nettype wire

[rtl/core/q24_8_fixed_point_alu.sv]
// q24_8_fixed_point_alu: signed Q24.8 ALU, saturating, fully pipelined
// depends on q24alu_pkg and q24alu_div
//
//   channel  direction  payload     handshake
//   in       input      in_word     in_valid / in_stall
//   out      output     out_word    out_valid / out_stall
//
// one word per cycle enters while the pipeline is not frozen; an accepted word passes the
// input register and then the PIPE_LAST stages before it is on out_word, a depth set by
// the divider, which resolves two quotient bits per stage
// all opcodes share one pipeline so results leave in order
// reset clears only the valid bits; out_stall freezes the whole pipeline only while a
// finished word is on the output, so in_stall is high while that word waits under stall
`default_nettype none

module q24_8_fixed_point_alu (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire q24alu_pkg::in_word_t  in_word,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output q24alu_pkg::out_word_t      out_word
);

  localparam int W = q24alu_pkg::WORD_BITS;
  localparam int F = q24alu_pkg::FRAC_BITS;
  localparam int L = q24alu_pkg::PIPE_LAST;

  logic                 en;
  logic                 in_v_r;
  logic [3:0]           in_op_r;
  logic [W-1:0]         in_a_r;
  logic [W-1:0]         in_b_r;
  q24alu_pkg::mid_t     pipe_r   [1:L];
  q24alu_pkg::mid_t     pipe_nxt [1:L];
  q24alu_pkg::mid_t     s1_nxt;
  logic [W-1:0]         ma_r, ma_nxt;
  logic [W-1:0]         mb_r, mb_nxt;
  logic [2*W-1:0]       prod_r;
  q24alu_pkg::div_res_t div_res;

  // decode stage signals
  logic [W-1:0]         sum, dif, incv, decv, fi_lim, ti_mag;
  logic                 lt, eq;
  q24alu_pkg::op_t      op_d;
  // pack stage signals
  logic [2*W:0]         mul_t;
  q24alu_pkg::calc_t    mul_c;
  q24alu_pkg::calc_t    div_c;

  // whole pipeline moves unless the output word is held
  assign en       = !(pipe_r[L].valid && out_stall);
  assign in_stall = !en;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (en) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_op_r <= in_word.op;
      in_a_r  <= in_word.a_raw;
      in_b_r  <= in_word.b_raw;
    end
  end

  // stage 1: simple ops, comparisons, operand magnitudes
  always_comb begin
    op_d   = q24alu_pkg::op_t'(in_op_r);
    sum    = in_a_r + in_b_r;
    dif    = in_a_r - in_b_r;
    incv   = in_a_r + q24alu_pkg::WORD_ONE;
    decv   = in_a_r - q24alu_pkg::WORD_ONE;
    lt     = ($signed(in_a_r) < $signed(in_b_r));
    eq     = (in_a_r == in_b_r);
    ma_nxt = q24alu_pkg::mag_of(in_a_r);
    mb_nxt = q24alu_pkg::mag_of(in_b_r);
    fi_lim = in_a_r[W-1] ? (q24alu_pkg::WORD_SIGN >> F) : (q24alu_pkg::WORD_MAX >> F);
    ti_mag = ma_nxt >> F;

    s1_nxt.valid = in_v_r;
    s1_nxt.op    = op_d;
    s1_nxt.neg   = in_a_r[W-1] ^ in_b_r[W-1];
    s1_nxt.res   = '0;
    s1_nxt.cmp   = 1'b0;
    s1_nxt.fault = q24alu_pkg::FLT_NONE;
    case (op_d)
      q24alu_pkg::OP_ADD: begin
        if (in_a_r[W-1] == in_b_r[W-1] && sum[W-1] != in_a_r[W-1]) begin
          s1_nxt.res   = q24alu_pkg::sat_val(in_a_r[W-1]);
          s1_nxt.fault = q24alu_pkg::FLT_OVF;
        end else begin
          s1_nxt.res = sum;
        end
      end
      q24alu_pkg::OP_SUB: begin
        if (in_a_r[W-1] != in_b_r[W-1] && dif[W-1] != in_a_r[W-1]) begin
          s1_nxt.res   = q24alu_pkg::sat_val(in_a_r[W-1]);
          s1_nxt.fault = q24alu_pkg::FLT_OVF;
        end else begin
          s1_nxt.res = dif;
        end
      end
      q24alu_pkg::OP_INC: begin
        if (!in_a_r[W-1] && incv[W-1]) begin
          s1_nxt.res   = q24alu_pkg::WORD_MAX;
          s1_nxt.fault = q24alu_pkg::FLT_OVF;
        end else begin
          s1_nxt.res = incv;
        end
      end
      q24alu_pkg::OP_DEC: begin
        if (in_a_r[W-1] && !decv[W-1]) begin
          s1_nxt.res   = q24alu_pkg::WORD_SIGN;
          s1_nxt.fault = q24alu_pkg::FLT_OVF;
        end else begin
          s1_nxt.res = decv;
        end
      end
      q24alu_pkg::OP_LT:  s1_nxt.cmp = lt;
      q24alu_pkg::OP_LE:  s1_nxt.cmp = lt || eq;
      q24alu_pkg::OP_GT:  s1_nxt.cmp = !lt && !eq;
      q24alu_pkg::OP_GE:  s1_nxt.cmp = !lt;
      q24alu_pkg::OP_EQ:  s1_nxt.cmp = eq;
      q24alu_pkg::OP_NE:  s1_nxt.cmp = !eq;
      q24alu_pkg::OP_MIN: s1_nxt.res = lt ? in_a_r : in_b_r;
      q24alu_pkg::OP_MAX: s1_nxt.res = (!lt && !eq) ? in_a_r : in_b_r;
      q24alu_pkg::OP_FROM_INT: begin
        if (ma_nxt > fi_lim) begin
          s1_nxt.res   = q24alu_pkg::sat_val(in_a_r[W-1]);
          s1_nxt.fault = q24alu_pkg::FLT_OVF;
        end else begin
          s1_nxt.res = in_a_r << F;
        end
      end
      q24alu_pkg::OP_TO_INT: begin
        s1_nxt.res = in_a_r[W-1] ? ((~ti_mag) + q24alu_pkg::WORD_ONE) : ti_mag;
      end
      default: s1_nxt.res = '0;
    endcase
  end

  // stage 3: round and pack the product; last stage: pack the quotient
  always_comb begin
    mul_t = {1'b0, prod_r} + ((2*W+1)'(1) << (F - 1));
    mul_c = q24alu_pkg::pack_mag(pipe_r[2].neg, mul_t >> F);
    div_c = q24alu_pkg::pack_mag(pipe_r[L-1].neg,
                                 {{(2*W-q24alu_pkg::DIV_BITS){1'b0}}, div_res.q});
    pipe_nxt[1] = s1_nxt;
    for (int k = 2; k <= L; k++) begin
      pipe_nxt[k] = pipe_r[k-1];
    end
    if (pipe_r[2].op == q24alu_pkg::OP_MUL) begin
      pipe_nxt[3].res   = mul_c.res;
      pipe_nxt[3].fault = mul_c.fault;
    end
    if (pipe_r[L-1].op == q24alu_pkg::OP_DIV) begin
      if (div_res.dz) begin
        pipe_nxt[L].res   = '0;
        pipe_nxt[L].fault = q24alu_pkg::FLT_DIV0;
      end else begin
        pipe_nxt[L].res   = div_c.res;
        pipe_nxt[L].fault = div_c.fault;
      end
    end
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= L; k++) begin
        pipe_r[k].valid <= 1'b0;
      end
    end else if (en) begin
      for (int k = 1; k <= L; k++) begin
        pipe_r[k] <= pipe_nxt[k];
      end
      ma_r   <= ma_nxt;
      mb_r   <= mb_nxt;
      prod_r <= ma_r * mb_r;
    end
  end

  // quotient path runs alongside
  q24alu_div u_div (
    .clk     (clk),
    .en      (en),
    .in_ma   (ma_r),
    .in_mb   (mb_r),
    .out_res (div_res)
  );

  // output word
  assign out_valid             = pipe_r[L].valid;
  assign out_word.result_raw   = pipe_r[L].res;
  assign out_word.compare_true = pipe_r[L].cmp;
  assign out_word.fault        = pipe_r[L].fault;

  // checks
  a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.fault == q24alu_pkg::FLT_DIV0 |-> out_word.result_raw == '0)
    else $error("divide by zero word carries a non-zero result");

  a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.compare_true
      |-> out_word.result_raw == '0 && out_word.fault == q24alu_pkg::FLT_NONE)
    else $error("comparison word carries result or fault");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.fault == q24alu_pkg::FLT_OVF
      |-> out_word.result_raw == q24alu_pkg::WORD_SIGN
       || out_word.result_raw == q24alu_pkg::WORD_MAX)
    else $error("overflow word not saturated");

endmodule

`default_nettype wire

[rtl/core/q24alu_div.sv]
// q24alu_div: pipelined restoring divider for magnitudes, quotient of
// (a << FRAC_BITS) / d rounded half up; depends on q24alu_pkg
`default_nettype none

module q24alu_div (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic [q24alu_pkg::WORD_BITS-1:0] in_ma,
  input  wire logic [q24alu_pkg::WORD_BITS-1:0] in_mb,
  output q24alu_pkg::div_res_t                  out_res
);

  q24alu_pkg::div_stage_t stg_r   [1:q24alu_pkg::DIV_STAGES];
  q24alu_pkg::div_stage_t stg_nxt [1:q24alu_pkg::DIV_STAGES];
  q24alu_pkg::div_stage_t first;
  q24alu_pkg::div_stage_t last;
  q24alu_pkg::div_res_t   res_r;
  q24alu_pkg::div_res_t   res_nxt;
  logic                   rnd;

  // entry: dividend is the magnitude shifted up by the fraction bits
  always_comb begin
    first.rem  = '0;
    first.nrem = {in_ma, {q24alu_pkg::FRAC_BITS{1'b0}}};
    first.q    = '0;
    first.d    = in_mb;
  end

  // two quotient bits per stage
  always_comb begin
    for (int j = 1; j <= q24alu_pkg::DIV_STAGES; j++) begin
      stg_nxt[j] = (j == 1) ? first : stg_r[(j > 1) ? j - 1 : 1];
      for (int i = 0; i < q24alu_pkg::DIV_PER_STAGE; i++) begin
        stg_nxt[j] = q24alu_pkg::div_step(stg_nxt[j]);
      end
    end
  end

  // round to nearest, ties away from zero
  always_comb begin
    last        = stg_r[q24alu_pkg::DIV_STAGES];
    rnd         = (last.rem >= (last.d - last.rem));
    res_nxt.q   = {1'b0, last.q} + {{q24alu_pkg::DIV_BITS{1'b0}}, rnd};
    res_nxt.dz  = (last.d == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 1; j <= q24alu_pkg::DIV_STAGES; j++) begin
        stg_r[j] <= stg_nxt[j];
      end
      res_r <= res_nxt;
    end
  end

  assign out_res = res_r;

endmodule

`default_nettype wire

[dv/tb_q24_8_fixed_point_alu.sv]
// testbench for the signed Q24.8 saturating ALU: directed corner words, a long hold-off, then random
// traffic with bursty sending and random stalls; depends on q24alu_pkg
`default_nettype none

module tb_q24_8_fixed_point_alu;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 60;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  q24alu_pkg::in_word_t  in_word = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  q24alu_pkg::out_word_t out_word;

  q24alu_pkg::out_word_t alu_expected[$];
  int        failures = 0;
  int        cycle_cnt = 0;
  bit        hold_off = 1'b0;

  q24_8_fixed_point_alu dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_word(in_word), .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // timeout
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("q24_8_fixed_point_alu test failed");
      $finish;
    end
  end

  // saturating pack of a sign and a wide magnitude
  function automatic q24alu_pkg::out_word_t fit_mag(input bit neg, input logic [127:0] m);
    q24alu_pkg::out_word_t r;
    logic [127:0] lim;
    r = '0;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (m > lim) begin
      r.result_raw = neg ? q24alu_pkg::WORD_SIGN : q24alu_pkg::WORD_MAX;
      r.fault = q24alu_pkg::FLT_OVF;
    end else begin
      r.result_raw = neg ? -m[31:0] : m[31:0];
    end
    return r;
  endfunction

  // expected result of one ALU word
  function automatic q24alu_pkg::out_word_t alu_predict(input q24alu_pkg::in_word_t w);
    q24alu_pkg::out_word_t r;
    logic signed [31:0] a, b;
    logic signed [63:0] s;
    logic [127:0] ma, mb, q, rm;
    bit neg;
    r = '0;
    a = w.a_raw;
    b = w.b_raw;
    ma = a[31] ? 128'(-64'(a)) : 128'(a);
    mb = b[31] ? 128'(-64'(b)) : 128'(b);
    neg = a[31] ^ b[31];
    case (q24alu_pkg::op_t'(w.op))
      q24alu_pkg::OP_ADD, q24alu_pkg::OP_SUB, q24alu_pkg::OP_INC, q24alu_pkg::OP_DEC: begin
        case (q24alu_pkg::op_t'(w.op))
          q24alu_pkg::OP_ADD: s = 64'(a) + 64'(b);
          q24alu_pkg::OP_SUB: s = 64'(a) - 64'(b);
          q24alu_pkg::OP_INC: s = 64'(a) + 1;
          default:            s = 64'(a) - 1;
        endcase
        if (s > 64'sh7fff_ffff) begin
          r.result_raw = q24alu_pkg::WORD_MAX; r.fault = q24alu_pkg::FLT_OVF;
        end else if (s < -64'sh8000_0000) begin
          r.result_raw = q24alu_pkg::WORD_SIGN; r.fault = q24alu_pkg::FLT_OVF;
        end else begin
          r.result_raw = s[31:0];
        end
      end
      q24alu_pkg::OP_MUL:
        r = fit_mag(neg, (ma * mb + 128'd128) >> q24alu_pkg::FRAC_BITS);
      q24alu_pkg::OP_DIV: begin
        if (mb == 0) begin
          r.fault = q24alu_pkg::FLT_DIV0;
        end else begin
          q = (ma << q24alu_pkg::FRAC_BITS) / mb;
          rm = (ma << q24alu_pkg::FRAC_BITS) % mb;
          if (rm >= mb - rm) q = q + 1;
          r = fit_mag(neg, q);
        end
      end
      q24alu_pkg::OP_LT: r.compare_true = a < b;
      q24alu_pkg::OP_LE: r.compare_true = a <= b;
      q24alu_pkg::OP_GT: r.compare_true = a > b;
      q24alu_pkg::OP_GE: r.compare_true = a >= b;
      q24alu_pkg::OP_EQ: r.compare_true = a == b;
      q24alu_pkg::OP_NE: r.compare_true = a != b;
      q24alu_pkg::OP_MIN: r.result_raw = (a < b) ? a : b;
      q24alu_pkg::OP_MAX: r.result_raw = (a > b) ? a : b;
      q24alu_pkg::OP_FROM_INT: r = fit_mag(a[31], ma << q24alu_pkg::FRAC_BITS);
      default: r.result_raw = a[31] ? -(ma[31:0] >> q24alu_pkg::FRAC_BITS)
                                    : (ma[31:0] >> q24alu_pkg::FRAC_BITS);
    endcase
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    q24alu_pkg::out_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (alu_expected.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_word);
        failures++;
      end else begin
        exp_w = alu_expected.pop_front();
        if (out_word.result_raw !== exp_w.result_raw) begin
          $display("%0t: result_raw expected %h actual %h", $time, exp_w.result_raw,
                   out_word.result_raw);
          failures++;
        end
        if (out_word.compare_true !== exp_w.compare_true) begin
          $display("%0t: compare_true expected %b actual %b", $time, exp_w.compare_true,
                   out_word.compare_true);
          failures++;
        end
        if (out_word.fault !== exp_w.fault) begin
          $display("%0t: fault expected %0d actual %0d", $time, exp_w.fault, out_word.fault);
          failures++;
        end
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    int mode;
    mode = (cycle_cnt / 300) % 3;
    if (hold_off) out_stall <= 1'b1;
    else if (mode == 0) out_stall <= 1'b0;
    else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= ($urandom_range(0, 1) == 0);
  end

  // send one word, waiting for acceptance
  task automatic send_word(input q24alu_pkg::op_t op, input logic [31:0] a,
                           input logic [31:0] b);
    q24alu_pkg::in_word_t w;
    w.op = op;
    w.a_raw = a;
    w.b_raw = b;
    in_valid <= 1'b1;
    in_word <= w;
    alu_expected.push_back(alu_predict(w));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return q24alu_pkg::WORD_MAX - $urandom_range(0, 2);
      1: return q24alu_pkg::WORD_SIGN + $urandom_range(0, 2);
      2: return $urandom_range(0, 1024) - 512;
      3: return $urandom_range(0, 65535) << $urandom_range(0, 16);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_word(q24alu_pkg::OP_ADD, q24alu_pkg::WORD_MAX, 32'd1);
    send_word(q24alu_pkg::OP_ADD, q24alu_pkg::WORD_SIGN, q24alu_pkg::WORD_SIGN);
    send_word(q24alu_pkg::OP_SUB, q24alu_pkg::WORD_SIGN, 32'd1);
    send_word(q24alu_pkg::OP_SUB, q24alu_pkg::WORD_MAX, 32'hffff_ffff);
    send_word(q24alu_pkg::OP_MUL, 32'h0000_0180, 32'h0000_0001);
    send_word(q24alu_pkg::OP_MUL, 32'hffff_fe80, 32'h0000_0001);
    send_word(q24alu_pkg::OP_MUL, q24alu_pkg::WORD_SIGN, q24alu_pkg::WORD_SIGN);
    send_word(q24alu_pkg::OP_MUL, q24alu_pkg::WORD_SIGN, 32'h0000_0100);
    send_word(q24alu_pkg::OP_DIV, 32'h0000_0100, 32'd0);
    send_word(q24alu_pkg::OP_DIV, q24alu_pkg::WORD_MAX, 32'd1);
    send_word(q24alu_pkg::OP_DIV, 32'h0000_0100, 32'h0000_0300);
    send_word(q24alu_pkg::OP_DIV, q24alu_pkg::WORD_SIGN, 32'hffff_ff00);
    send_word(q24alu_pkg::OP_LT, q24alu_pkg::WORD_SIGN, q24alu_pkg::WORD_MAX);
    send_word(q24alu_pkg::OP_LE, 32'd5, 32'd5);
    send_word(q24alu_pkg::OP_GT, 32'hffff_ffff, 32'd0);
    send_word(q24alu_pkg::OP_GE, q24alu_pkg::WORD_MAX, q24alu_pkg::WORD_SIGN);
    send_word(q24alu_pkg::OP_EQ, 32'd7, 32'd7);
    send_word(q24alu_pkg::OP_NE, 32'd7, 32'd7);
    send_word(q24alu_pkg::OP_MIN, q24alu_pkg::WORD_SIGN, q24alu_pkg::WORD_MAX);
    send_word(q24alu_pkg::OP_MAX, q24alu_pkg::WORD_SIGN, q24alu_pkg::WORD_MAX);
    send_word(q24alu_pkg::OP_INC, q24alu_pkg::WORD_MAX, 32'd0);
    send_word(q24alu_pkg::OP_DEC, q24alu_pkg::WORD_SIGN, 32'd0);
    send_word(q24alu_pkg::OP_FROM_INT, 32'h0080_0000, 32'd0);
    send_word(q24alu_pkg::OP_FROM_INT, 32'hff80_0000, 32'd0);
    send_word(q24alu_pkg::OP_TO_INT, 32'hffff_ff01, 32'd0);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_random(input int count);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 2) != 0) pause_sender();
        burst = $urandom_range(1, 30);
      end
      send_word(q24alu_pkg::op_t'($urandom_range(0, 15)), rand_operand(), rand_operand());
      burst--;
    end
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // long receiver hold-off while the sender keeps offering words
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (120) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 60; i++)
          send_word(q24alu_pkg::op_t'($urandom_range(0, 15)), $urandom, $urandom);
        in_valid <= 1'b0;
        @(posedge clk);
      end
    join
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(480);
    while (alu_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("q24_8_fixed_point_alu test passed");
    end else begin
      $display("q24_8_fixed_point_alu test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/core/q24alu_pkg.sv
rtl/core/q24alu_div.sv
rtl/core/q24_8_fixed_point_alu.sv
dv/tb_q24_8_fixed_point_alu.sv
